// File: rtl/core/assert_macros.svh
// Assertion macros shared by the saturation pressure core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TSP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tsp core assertion failed");

// Check a property on every clock edge, reset included.
`define TSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tsp core assertion failed");

`endif

// File: rtl/core/tsp_pkg.sv
// Types and constants of the saturation vapour pressure core.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DOM = 2'd2
  } status_e;

  // Control that travels with each beat down the pipeline
  typedef struct packed {
    logic    vld;
    logic    done;
    status_e st;
  } tsp_tag_t;

  // Tag plus the sign of the exponent argument
  typedef struct packed {
    logic     gneg;
    tsp_tag_t tag;
  } tsp_sgn_tag_t;

  // Tag plus the integer part of the biased exponent
  typedef struct packed {
    logic [6:0] nb;
    tsp_tag_t   tag;
  } tsp_exp_tag_t;

  // Register indexes
  localparam logic [0:0] REG_TEMP_SCALE     = 1'b0;
  localparam logic [0:0] REG_PRESSURE_RECIP = 1'b1;

  localparam logic [31:0] TEMP_SCALE_RST     = 32'd17901158;
  localparam logic [31:0] PRESSURE_RECIP_RST = 32'd10995116;

  // Widths along the datapath
  localparam int unsigned TAG_W  = $bits(tsp_tag_t);
  localparam int unsigned SGN_W  = $bits(tsp_sgn_tag_t);
  localparam int unsigned EXP_W  = $bits(tsp_exp_tag_t);
  localparam int unsigned DEN_W  = 42;
  localparam int unsigned Q1_W   = 34;
  localparam int unsigned Q2_W   = 38;
  localparam int unsigned YB_W   = 39;
  localparam int unsigned PTOP_W = 93;
  localparam int unsigned TAYLOR_N = 14;

  // Pole and span of the Tetens quotient, in milli-Kelvin Q.16
  localparam logic [41:0] POLE_M   = 42'd33639 << 16;
  localparam logic [41:0] SPAN_M   = 42'd239521 << 16;
  localparam logic [41:0] POLE_LO  = POLE_M - 42'd1000;
  localparam logic [41:0] POLE_HI  = POLE_M + 42'd1000;
  localparam logic [43:0] LIM3     = {2'b00, SPAN_M} + 44'd3 * {2'b00, POLE_M};
  localparam logic [41:0] DIV_REM0 = SPAN_M >> 2;

  localparam logic [33:0] ONE_Q32   = 34'h1_0000_0000;
  localparam logic [17:0] COEF_NUM  = 18'd174146;
  localparam logic [13:0] COEF_DEN  = 14'd10000;
  localparam logic [63:0] LOG2E_Q63 = 64'hB8AA_3B29_5C17_F0BC;
  localparam logic [63:0] LN2_Q64   = 64'hB172_17F7_D1CF_79AB;
  localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
  localparam logic [38:0] YB_BIAS   = 39'h40_0000_0000;
  localparam logic [6:0]  SHIFT_BASE = 7'd122;

  // Reciprocal of the coefficient denominator, exact for dividends below 2^51
  localparam int unsigned  COEF_SH     = 65;
  localparam logic [127:0] CoefRcpFull =
    ((128'd1 << COEF_SH) + 128'(COEF_DEN) - 128'd1) / 128'(COEF_DEN);
  localparam logic [63:0]  COEF_RCP    = CoefRcpFull[63:0];

  localparam logic [63:0] PtripFull = ((64'd611655 << 20) + 64'd500) / 64'd1000;
  localparam logic [29:0] PTRIP_Q20 = PtripFull[29:0];

  localparam logic [47:0] OUT_MAX = 48'hFFFF_FFFF_FFFF;

endpackage

`default_nettype wire

// File: rtl/core/tsp_div_cell.sv
// One restoring division cell: one quotient bit per beat.
`timescale 1ns / 1ps
`default_nettype none

module tsp_div_cell #(
  parameter int unsigned DenW = 42,
  parameter int unsigned NumW = 34,
  parameter int unsigned TagW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [DenW-1:0] rem_i,
  input  logic [NumW-1:0] nq_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic [DenW-1:0] rem_o,
  output logic [NumW-1:0] nq_o,
  output logic [DenW-1:0] den_o,
  output logic [TagW-1:0] tag_o
);

  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            take;
  logic [DenW-1:0] rem_d, rem_q;
  logic [NumW-1:0] nq_d, nq_q;
  logic [DenW-1:0] den_q;
  logic [TagW-1:0] tag_q;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_i, nq_i[NumW-1]};
  assign diff  = trial - {1'b0, den_i};
  assign take  = (trial >= {1'b0, den_i});
  assign rem_d = take ? diff[DenW-1:0] : trial[DenW-1:0];
  assign nq_d  = {nq_i[NumW-2:0], take};

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      den_q <= den_i;
    end
  end

  // Advance the control tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  assign rem_o = rem_q;
  assign nq_o  = nq_q;
  assign den_o = den_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

// File: rtl/core/tsp_mul.sv
// Three-stage 64x64 multiplier returning the product shifted right.
`timescale 1ns / 1ps
`default_nettype none

module tsp_mul #(
  parameter int unsigned Sh   = 62,
  parameter int unsigned OutW = 64,
  parameter int unsigned TagW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [63:0]     a_i,
  input  logic [63:0]     b_i,
  input  logic [TagW-1:0] tag_i,
  output logic [OutW-1:0] res_o,
  output logic [TagW-1:0] tag_o
);

  localparam int unsigned TopSh = Sh - 32;

  logic [63:0]     pp00_q, pp01_q, pp10_q, pp11_q;
  logic [65:0]     mid_d, mid_q;
  logic [63:0]     hi2_q;
  logic [96:0]     top;
  logic [96:0]     top_sh;
  logic [OutW-1:0] res_q;
  logic [TagW-1:0] tag1_q, tag2_q, tag3_q;

  // Sum the middle partial products with the carry-out of the low one
  assign mid_d  = {2'b00, pp10_q} + {2'b00, pp01_q} + {34'd0, pp00_q[63:32]};
  assign top    = {1'b0, hi2_q, 32'd0} + {31'd0, mid_q};
  assign top_sh = top >> TopSh;

  // Form partial products, then reduce in two steps
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= {32'd0, a_i[31:0]}  * {32'd0, b_i[31:0]};
      pp01_q <= {32'd0, a_i[31:0]}  * {32'd0, b_i[63:32]};
      pp10_q <= {32'd0, a_i[63:32]} * {32'd0, b_i[31:0]};
      pp11_q <= {32'd0, a_i[63:32]} * {32'd0, b_i[63:32]};
      mid_q  <= mid_d;
      hi2_q  <= pp11_q;
      res_q  <= top_sh[OutW-1:0];
    end
  end

  // Advance the tag alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  assign res_o = res_q;
  assign tag_o = tag3_q;

endmodule

`default_nettype wire

// File: rtl/core/tsp_taylor_cell.sv
// One Horner step of the 2^f series: acc = 1 + (u * acc) / K.
`timescale 1ns / 1ps
`default_nettype none

module tsp_taylor_cell #(
  parameter int unsigned K    = 14,
  parameter int unsigned TagW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [63:0]     u_i,
  input  logic [63:0]     acc_i,
  input  logic [TagW-1:0] tag_i,
  output logic [63:0]     u_o,
  output logic [63:0]     acc_o,
  output logic [TagW-1:0] tag_o
);

  import tsp_pkg::*;

  // Exact reciprocal of K for any dividend below 2^63
  localparam int unsigned RcpSh   = 63 + $clog2(K);
  localparam logic [127:0] RcpFull =
    ((128'd1 << RcpSh) + 128'(K) - 128'd1) / 128'(K);
  localparam logic [63:0] Rcp = RcpFull[63:0];

  logic [63:0]      prod;
  logic [TagW+63:0] prod_tag;
  logic [63:0]      quo;
  logic [TagW+63:0] quo_tag;
  logic [63:0]      u_q, acc_q;
  logic [TagW-1:0]  tag_q;

  // Multiply by the running sum, Q.62
  tsp_mul #(.Sh(62), .OutW(64), .TagW(TagW + 64)) u_mul_acc (
    .clk_i, .rst_ni, .en_i,
    .a_i(u_i), .b_i(acc_i), .tag_i({u_i, tag_i}),
    .res_o(prod), .tag_o(prod_tag)
  );

  // Divide by K through its reciprocal
  tsp_mul #(.Sh(RcpSh), .OutW(64), .TagW(TagW + 64)) u_mul_rcp (
    .clk_i, .rst_ni, .en_i,
    .a_i(prod), .b_i(Rcp), .tag_i(prod_tag),
    .res_o(quo), .tag_o(quo_tag)
  );

  // Add one and hand on
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q   <= quo_tag[TagW+63:TagW];
      acc_q <= ONE_Q62 + quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= quo_tag[TagW-1:0];
    end
  end

  assign u_o   = u_q;
  assign acc_o = acc_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

// File: rtl/core/tetens_saturation_pressure_core.sv
// Top level of the Tetens saturation vapour pressure core.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i          | in
//  input    | in_valid_i/in_ready_o, temp_scaled_i     | in
//  result   | out_valid_o/out_ready_i, psat_scaled_o,  | out
//           | status_o                                 |
//
// One beat enters per cycle unless a result waits in the output register.
// The pipeline holds the bit-serial division chain (34 cells), the fourteen
// Horner cells of 2^f, each with two pipelined multipliers, and four further
// three-stage multipliers around them.
// Reset empties the pipeline and loads the default scale registers.
// A result beat waiting in the output register freezes every stage and drops
// in_ready_o until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tetens_saturation_pressure_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] temp_scaled_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] psat_scaled_o,
  output logic [1:0]  status_o
);

  import tsp_pkg::*;

  logic en;
  logic accept;

  logic [31:0] temp_scale_q, pressure_recip_q;
  logic [61:0] c_d, c_q;

  logic [63:0] a_prod;
  logic [31:0] a_t16_d, a_t16_q;
  logic        a_vld_q, a_zero_q;

  logic [41:0] b_tm_q;
  logic [43:0] b_tm3_q;
  logic        b_vld_q, b_zero_q;

  tsp_tag_t    c_tag_d, c_tag_q;
  logic [41:0] c_den_q;

  logic [DEN_W-1:0] d1_rem [Q1_W+1];
  logic [Q1_W-1:0]  d1_nq  [Q1_W+1];
  logic [DEN_W-1:0] d1_den [Q1_W+1];
  tsp_tag_t         d1_tag [Q1_W+1];

  logic [33:0] d_q;
  logic        d_gneg;
  logic [33:0] d_gmag;
  logic [33:0] d_gmag_q;
  tsp_sgn_tag_t d_tag_q;

  logic [51:0] e_x_d;
  logic [50:0] e_x_q;
  tsp_sgn_tag_t e_tag_q;

  logic [Q2_W-1:0] a_mag;
  tsp_sgn_tag_t    a_tag;

  logic [YB_W-1:0] ymag;
  tsp_sgn_tag_t    y_tag;
  logic [YB_W-1:0] f_yb_d, f_yb_q;
  tsp_tag_t        f_tag_q;
  tsp_exp_tag_t    f_etag;

  logic [63:0]  t_u   [TAYLOR_N+1];
  logic [63:0]  t_acc [TAYLOR_N+1];
  tsp_exp_tag_t t_tag [TAYLOR_N+1];

  logic [PTOP_W-1:0] p_top;
  tsp_exp_tag_t      p_tag;
  logic [6:0]        shamt;
  logic [PTOP_W-1:0] res_sh;
  logic              res_sat;

  logic        out_valid_q;
  logic [47:0] psat_d, psat_q;
  status_e     status_d, status_q;

  // Move when the output register is free or being drained
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_scale_q     <= TEMP_SCALE_RST;
      pressure_recip_q <= PRESSURE_RECIP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEMP_SCALE:     temp_scale_q     <= cfg_data_i;
        REG_PRESSURE_RECIP: pressure_recip_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pressure coefficient times the reciprocal scale
  assign c_d = {30'd0, pressure_recip_q} * {32'd0, PTRIP_Q20};
  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  // Scale to Kelvin, saturating at the top of Q16.16
  assign a_prod  = {32'd0, temp_scaled_i} * {32'd0, temp_scale_q};
  assign a_t16_d = (|a_prod[63:62]) ? 32'hFFFF_FFFF : a_prod[61:30];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_t16_q  <= a_t16_d;
      a_zero_q <= (temp_scaled_i == 32'd0);
      b_tm_q   <= {10'd0, a_t16_q} * 42'd1000;
      b_tm3_q  <= {12'd0, a_t16_q} * 44'd3000;
      b_zero_q <= a_zero_q;
      c_den_q  <= b_tm_q - POLE_M;
    end
  end

  // Sort out the special cases ahead of the division
  always_comb begin
    c_tag_d      = '0;
    c_tag_d.vld  = b_vld_q;
    c_tag_d.done = 1'b1;
    c_tag_d.st   = ST_OK;
    priority if (b_zero_q) begin
      c_tag_d.st = ST_DOM;
    end else if ((b_tm_q > POLE_LO) && (b_tm_q < POLE_HI)) begin
      c_tag_d.st = ST_DOM;
    end else if (pressure_recip_q == 32'd0) begin
      c_tag_d.st = ST_OK;
    end else if (b_tm_q < POLE_M) begin
      c_tag_d.st = ST_SAT;
    end else if (b_tm3_q < LIM3) begin
      c_tag_d.st = ST_OK;
    end else begin
      c_tag_d.done = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_tag_q <= '0;
    end else if (en) begin
      a_vld_q <= accept;
      b_vld_q <= a_vld_q;
      c_tag_q <= c_tag_d;
    end
  end

  // Quotient span / (T - pole) in Q.32, one bit per cell
  assign d1_rem[0] = DIV_REM0;
  assign d1_nq[0]  = '0;
  assign d1_den[0] = c_den_q;
  assign d1_tag[0] = c_tag_q;

  for (genvar gi = 0; gi < Q1_W; gi++) begin : g_div1
    tsp_div_cell #(.DenW(DEN_W), .NumW(Q1_W), .TagW(TAG_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .rem_i(d1_rem[gi]), .nq_i(d1_nq[gi]), .den_i(d1_den[gi]), .tag_i(d1_tag[gi]),
      .rem_o(d1_rem[gi+1]), .nq_o(d1_nq[gi+1]), .den_o(d1_den[gi+1]),
      .tag_o(d1_tag[gi+1])
    );
  end

  // Take the magnitude of 1 - q
  assign d_q    = d1_nq[Q1_W];
  assign d_gneg = (d_q > ONE_Q32);
  assign d_gmag = d_gneg ? (d_q - ONE_Q32) : (ONE_Q32 - d_q);
  assign e_x_d  = {18'd0, d_gmag_q} * {34'd0, COEF_NUM};

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_gmag_q <= d_gmag;
      e_x_q    <= e_x_d[50:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_tag_q <= '0;
      e_tag_q <= '0;
    end else if (en) begin
      d_tag_q <= '{gneg: d_gneg, tag: d1_tag[Q1_W]};
      e_tag_q <= d_tag_q;
    end
  end

  // Divide by the coefficient denominator through its reciprocal
  tsp_mul #(.Sh(COEF_SH), .OutW(Q2_W), .TagW(SGN_W)) u_mul_coef (
    .clk_i, .rst_ni, .en_i(en),
    .a_i({13'd0, e_x_q}), .b_i(COEF_RCP), .tag_i(e_tag_q),
    .res_o(a_mag), .tag_o(a_tag)
  );

  // Convert to a base-2 exponent
  tsp_mul #(.Sh(63), .OutW(YB_W), .TagW(SGN_W)) u_mul_log2e (
    .clk_i, .rst_ni, .en_i(en),
    .a_i({26'd0, a_mag}), .b_i(LOG2E_Q63), .tag_i(a_tag),
    .res_o(ymag), .tag_o(y_tag)
  );

  // Bias the exponent so the integer part stays positive
  assign f_yb_d = y_tag.gneg ? (YB_BIAS - ymag) : (YB_BIAS + ymag);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_yb_q <= f_yb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_tag_q <= '0;
    end else if (en) begin
      f_tag_q <= y_tag.tag;
    end
  end

  assign f_etag = '{nb: f_yb_q[38:32], tag: f_tag_q};

  // Fraction times ln 2 in Q.62
  tsp_mul #(.Sh(34), .OutW(64), .TagW(EXP_W)) u_mul_ln2 (
    .clk_i, .rst_ni, .en_i(en),
    .a_i({32'd0, f_yb_q[31:0]}), .b_i(LN2_Q64), .tag_i(f_etag),
    .res_o(t_u[0]), .tag_o(t_tag[0])
  );

  // Horner chain for 2^f, highest term first
  assign t_acc[0] = ONE_Q62;

  for (genvar gk = 0; gk < TAYLOR_N; gk++) begin : g_taylor
    tsp_taylor_cell #(.K(TAYLOR_N - gk), .TagW(EXP_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .u_i(t_u[gk]), .acc_i(t_acc[gk]), .tag_i(t_tag[gk]),
      .u_o(t_u[gk+1]), .acc_o(t_acc[gk+1]), .tag_o(t_tag[gk+1])
    );
  end

  // Scale 2^f by the pressure coefficient
  tsp_mul #(.Sh(32), .OutW(PTOP_W), .TagW(EXP_W)) u_mul_scale (
    .clk_i, .rst_ni, .en_i(en),
    .a_i(t_acc[TAYLOR_N]), .b_i({2'b00, c_q}), .tag_i(t_tag[TAYLOR_N]),
    .res_o(p_top), .tag_o(p_tag)
  );

  // Apply the integer power and saturate
  assign shamt   = SHIFT_BASE - p_tag.nb;
  assign res_sh  = p_top >> shamt;
  assign res_sat = |res_sh[PTOP_W-1:48];

  always_comb begin
    priority if (p_tag.tag.done) begin
      status_d = p_tag.tag.st;
      psat_d   = (p_tag.tag.st == ST_SAT) ? OUT_MAX : 48'd0;
    end else if (res_sat) begin
      status_d = ST_SAT;
      psat_d   = OUT_MAX;
    end else begin
      status_d = ST_OK;
      psat_d   = res_sh[47:0];
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (en) begin
      psat_q   <= psat_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p_tag.tag.vld;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign psat_scaled_o = psat_q;
  assign status_o      = status_q;

  `TSP_ASSERT(a_sat_is_max, clk_i, rst_ni,
    (out_valid_o && (status_o == ST_SAT)) |-> (psat_scaled_o == OUT_MAX))
  `TSP_ASSERT(a_dom_is_zero, clk_i, rst_ni,
    (out_valid_o && (status_o == ST_DOM)) |-> (psat_scaled_o == 48'd0))
  `TSP_ASSERT_ALWAYS(a_reset_empty, clk_i, (!rst_ni) |-> (!out_valid_o))

endmodule

`default_nettype wire

// File: test/tetens_saturation_pressure_core_test.sv
// Self-checking testbench for the Tetens saturation vapour pressure core.
`timescale 1ns / 1ps

module tetens_saturation_pressure_core_test;
  import tsp_pkg::*;

  localparam int unsigned LATENCY_WAIT = 250;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = REG_TEMP_SCALE;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] temp_scaled_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [47:0] psat_scaled_o;
  logic [1:0]  status_o;

  tetens_saturation_pressure_core dut (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the scale registers
  logic [31:0] temp_scale_q     = TEMP_SCALE_RST;
  logic [31:0] pressure_recip_q = PRESSURE_RECIP_RST;

  logic [31:0] pending_temps[$];
  logic [47:0] psat_expected[$];
  status_e     status_expected[$];

  // Field extremes and a sweep around ambient
  logic [31:0] corner_temps [8] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h4000_0000,
                                    32'h8000_0000, 32'h3000_0000, 32'h5000_0000,
                                    32'h0100_0000};
  // Just below the pole, further below it and into deep underflow at one Kelvin per unit
  logic [31:0] pole_temps [9] = '{32'd2204547, 32'd2204548, 32'd2204549, 32'd2204550,
                                  32'd2204551, 32'd2204552, 32'd2204000, 32'd6553600,
                                  32'd2097152};

  int unsigned beats_in = 0, beats_out = 0, mismatches = 0, cycles = 0;
  int unsigned sat_seen = 0, dom_seen = 0;
  int unsigned idle_mode = 0;
  bit          taken = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  // 2^f, f in Q.32, evaluated as a Horner series of exp(f*ln2) in Q.62
  function automatic logic [63:0] pow2_q62(input logic [31:0] f);
    logic [127:0] w;
    logic [63:0]  u, acc;
    w = 128'({2'b00, f, 30'd0}) * 128'(LN2_Q64);
    u = w[127:64];
    acc = ONE_Q62;
    for (int k = TAYLOR_N; k >= 1; k--) begin
      w = 128'(u) * 128'(acc);
      acc = ONE_Q62 + w[125:62] / 64'(k);
    end
    return acc;
  endfunction

  // Saturation pressure and status for one temperature under the current scales
  task automatic predict_psat(input logic [31:0] t, output logic [47:0] psat,
                              output status_e st);
    logic [63:0]  t16, tm, den, qi, rem, f1, f2, q, gmag, a, ymag, yb, nb, s, c, p, r;
    logic [127:0] w;
    logic         gneg;
    psat = '0;
    st = ST_OK;
    t16 = (64'(t) * 64'(temp_scale_q)) >> 30;
    if (t16 > 64'hFFFF_FFFF) t16 = 64'hFFFF_FFFF;
    tm = t16 * 64'd1000;
    if (t == '0) begin
      st = ST_DOM;
    end else if (tm + 64'd1000 > 64'(POLE_M) && tm < 64'(POLE_M) + 64'd1000) begin
      st = ST_DOM;
    end else if (pressure_recip_q == '0) begin
      psat = '0;
    end else if (tm < 64'(POLE_M)) begin
      psat = OUT_MAX;
      st = ST_SAT;
    end else begin
      den = tm - 64'(POLE_M);
      // deep underflow: true value is below one unit of the last place
      if (64'(SPAN_M) <= 64'd3 * den) begin
        qi = 64'(SPAN_M) / den;
        rem = 64'(SPAN_M) % den;
        f1 = (rem << 16) / den;
        rem = (rem << 16) % den;
        f2 = (rem << 16) / den;
        q = (qi << 32) | (f1 << 16) | f2;
        gneg = q > 64'(ONE_Q32);
        gmag = gneg ? q - 64'(ONE_Q32) : 64'(ONE_Q32) - q;
        a = gmag * 64'(COEF_NUM) / 64'(COEF_DEN);
        w = 128'(a) * 128'(LOG2E_Q63);
        ymag = w[126:63];
        yb = gneg ? (64'd64 << 32) - ymag : (64'd64 << 32) + ymag;
        nb = yb >> 32;
        p = pow2_q62(yb[31:0]);
        c = 64'(pressure_recip_q) * 64'(PTRIP_Q20);
        s = 64'd154 - nb;
        if (s[31:0] >= 32'd128) begin
          r = '0;
        end else begin
          w = (128'(p) * 128'(c)) >> s[31:0];
          r = w[63:0];
        end
        if (r > 64'(OUT_MAX)) begin
          psat = OUT_MAX;
          st = ST_SAT;
        end else begin
          psat = r[47:0];
        end
      end
    end
  endtask

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Accept input beats and queue their predicted results
  always @(posedge clk_i) begin
    logic [47:0] ps;
    status_e     st;
    taken = 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_psat(temp_scaled_i, ps, st);
      psat_expected.push_back(ps);
      status_expected.push_back(st);
      void'(pending_temps.pop_front());
      beats_in++;
      taken = 1'b1;
    end
  end

  // Driver: present the next temperature, idling at random until 434 beats have gone in
  always @(negedge clk_i) begin
    int unsigned idle_pct;
    idle_mode = beats_in < 217 ? 0 : (beats_in < 434 ? 1 : 2);
    idle_pct = idle_mode == 0 ? 13 : (idle_mode == 1 ? 77 : 0);
    if (!in_valid_i || taken) begin
      if (rst_ni && pending_temps.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        temp_scaled_i <= pending_temps[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, so the pipeline fills and stalls its input
  always @(negedge clk_i) begin
    if (!hold_done && beats_in >= 480) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready
  always @(negedge clk_i) begin
    int unsigned idle_pct;
    idle_pct = idle_mode == 0 ? 77 : (idle_mode == 1 ? 13 : 0);
    out_ready_i <= rst_ni && hold_left == 0 && $urandom_range(99) >= idle_pct;
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (status_o == ST_SAT) sat_seen++;
      if (status_o == ST_DOM) dom_seen++;
      if (psat_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: psat %h status %0d",
                                       psat_scaled_o, status_o);
      end else begin
        if (psat_scaled_o !== psat_expected[0] || status_o !== status_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at beat %0d: psat exp %h got %h, status exp %0d got %0d",
                     beats_out, psat_expected[0], psat_scaled_o,
                     status_expected[0], status_o);
        end
        void'(psat_expected.pop_front());
        void'(status_expected.pop_front());
      end
    end
  end

  // Write both scales while the core is idle
  task automatic write_scales(input logic [31:0] ts, input logic [31:0] pr);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_TEMP_SCALE;
    cfg_data_i <= ts;
    @(negedge clk_i);
    cfg_idx_i <= REG_PRESSURE_RECIP;
    cfg_data_i <= pr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    temp_scale_q = ts;
    pressure_recip_q = pr;
  endtask

  // Wait for the queue to drain and every result to arrive
  task automatic drain;
    wait (pending_temps.size() == 0 && !in_valid_i && psat_expected.size() == 0);
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  // Mostly near-ambient temperatures, with some over the whole field
  function automatic logic [31:0] near_ambient();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(32'h5400_0000, 32'h2C00_0000);
  endfunction

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default scales: field extremes and a sweep around ambient
    foreach (corner_temps[i]) pending_temps.push_back(corner_temps[i]);
    repeat (150) pending_temps.push_back(near_ambient());
    drain();

    // One Kelvin per input unit in Q.16: just below the pole, further below and deep underflow
    write_scales(32'h4000_0000, PRESSURE_RECIP_RST);
    foreach (pole_temps[i]) pending_temps.push_back(pole_temps[i]);
    repeat (80) pending_temps.push_back($urandom_range(32'h0200_0000, 32'h0020_0000));
    drain();

    // Smallest temperature scale, largest pressure scale
    write_scales(32'd1, 32'hFFFF_FFFF);
    repeat (40) pending_temps.push_back($urandom);
    drain();

    // Largest temperature scale, smallest pressure scale
    write_scales(32'hFFFF_FFFF, 32'd1);
    repeat (60) pending_temps.push_back($urandom);
    drain();

    // Default temperature scale with overflowing pressure scale
    write_scales(TEMP_SCALE_RST, 32'hFFFF_FFFF);
    repeat (120) pending_temps.push_back(near_ambient());
    drain();

    // Random scales near the defaults
    write_scales($urandom_range(32'h0130_0000, 32'h00F0_0000), $urandom_range(32'h00FF_FFFF, 1));
    repeat (200) pending_temps.push_back(near_ambient());
    drain();

    $display("Sent %0d temperatures over six scale settings, checked %0d results",
             beats_in, beats_out);
    $display("Results saturated: %0d, domain errors: %0d, mismatches: %0d",
             sat_seen, dom_seen, mismatches);
    if (mismatches == 0 && psat_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
